FILE: src/sgdm_pkg.sv
package sgdm_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECAY           = 2'd0,
    REG_MOMENTUM_FACTOR = 2'd1,
    REG_LEARN_RATE      = 2'd2
  } cfg_reg_t;

  localparam logic [31:0] QNAN    = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_ALL = 8'hFF;

  // Leading-zero count of a 48-bit product.
  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Leading-zero count of a 27-bit extended mantissa.
  function automatic logic [4:0] lzc27(input logic [26:0] x);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (x[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage

FILE: src/sgdm_if.sv
// Input item channel.
interface sgdm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] weight_in;
  logic [31:0] grad_in;
  logic [31:0] mbuf_in;
  logic        last_element;
  modport source(output valid, weight_in, grad_in, mbuf_in, last_element, input ready);
  modport sink(input valid, weight_in, grad_in, mbuf_in, last_element, output ready);
endinterface

// Result item channel.
interface sgdm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] grad_out;
  logic [31:0] mbuf_out;
  logic [31:0] weight_out;
  logic        last_out;
  modport source(output valid, grad_out, mbuf_out, weight_out, last_out, input ready);
  modport sink(input valid, grad_out, mbuf_out, weight_out, last_out, output ready);
endinterface

// Configuration write channel.
interface sgdm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sgdm_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/sgdm_delay.sv
module sgdm_delay #(
  parameter int W     = 32,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // Shift line that moves with the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

FILE: src/sgdm_fmul.sv
module sgdm_fmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        vout,
  output logic [31:0] y
);
  import sgdm_pkg::*;

  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [8:0]  ea_eff, eb_eff;
  logic [23:0] ma, mb;

  logic        s1_valid, s1_sign, s1_nan, s1_inf;
  logic [47:0] s1_prod;
  logic [8:0]  s1_esum;

  logic               s2_valid, s2_sign, s2_nan, s2_inf, s2_zero;
  logic [47:0]        s2_prod;
  logic [5:0]         s2_lz;
  logic signed [10:0] s2_exp;

  logic               s3_valid, s3_sign, s3_nan, s3_inf, s3_zero;
  logic [47:0]        s3_pn;
  logic signed [10:0] s3_exp;
  logic [5:0]         s3_rsh;
  logic signed [10:0] rsh_full;

  logic [47:0] kept;
  logic        lost, grd, stk, inc, ovf;
  logic [7:0]  exp_f;
  logic [30:0] rounded;
  logic [31:0] res;

  // Operand classification and subnormal handling.
  always_comb begin
    nan_a  = (a[30:23] == EXP_ALL) && (a[22:0] != '0);
    nan_b  = (b[30:23] == EXP_ALL) && (b[22:0] != '0);
    inf_a  = (a[30:23] == EXP_ALL) && (a[22:0] == '0);
    inf_b  = (b[30:23] == EXP_ALL) && (b[22:0] == '0);
    zero_a = (a[30:0] == '0);
    zero_b = (b[30:0] == '0);
    ea_eff = (a[30:23] == '0) ? 9'd1 : {1'b0, a[30:23]};
    eb_eff = (b[30:23] == '0) ? 9'd1 : {1'b0, b[30:23]};
    ma     = {a[30:23] != '0, a[22:0]};
    mb     = {b[30:23] != '0, b[22:0]};
  end

  // Stage 1: mantissa product.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign <= a[31] ^ b[31];
      s1_nan  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
      s1_inf  <= inf_a | inf_b;
      s1_prod <= ma * mb;
      s1_esum <= ea_eff + eb_eff;
    end
  end

  // Stage 2: leading-zero count and biased exponent.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign <= s1_sign;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= (s1_prod == '0);
      s2_prod <= s1_prod;
      s2_lz   <= lzc48(s1_prod);
      s2_exp  <= $signed(11'(s1_esum)) - 11'sd126 - $signed(11'(lzc48(s1_prod)));
    end
  end

  assign rsh_full = 11'sd1 - s2_exp;

  // Stage 3: normalize, work out the denormalizing shift.
  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign <= s2_sign;
      s3_nan  <= s2_nan;
      s3_inf  <= s2_inf;
      s3_zero <= s2_zero;
      s3_pn   <= s2_prod << s2_lz;
      s3_exp  <= s2_exp;
      if (s2_exp > 11'sd0) begin
        s3_rsh <= '0;
      end else if (rsh_full > 11'sd49) begin
        s3_rsh <= 6'd49;
      end else begin
        s3_rsh <= rsh_full[5:0];
      end
    end
  end

  // Stage 4: round to nearest even and pack.
  always_comb begin
    kept    = s3_pn >> s3_rsh;
    lost    = |(s3_pn & ~({48{1'b1}} << s3_rsh));
    exp_f   = (s3_exp > 11'sd0) ? s3_exp[7:0] : 8'd0;
    ovf     = (s3_exp >= 11'sd255);
    grd     = kept[23];
    stk     = (|kept[22:0]) | lost;
    inc     = grd & (stk | kept[24]);
    rounded = {exp_f, kept[46:24]} + 31'(inc);
    if (s3_nan) begin
      res = QNAN;
    end else if (s3_inf || ovf) begin
      res = {s3_sign, EXP_ALL, 23'd0};
    end else if (s3_zero) begin
      res = {s3_sign, 31'd0};
    end else begin
      res = {s3_sign, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (en) y <= res;
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      vout     <= 1'b0;
    end else if (en) begin
      s1_valid <= vin;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      vout     <= s3_valid;
    end
  end

endmodule

FILE: src/sgdm_fadd.sv
module sgdm_fadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        vin,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        vout,
  output logic [31:0] y
);
  import sgdm_pkg::*;

  logic        nan_a, nan_b, inf_a, inf_b, swap;
  logic [31:0] big, sml;
  logic [7:0]  eb_eff, es_eff, ediff;

  logic        s1_valid, s1_sign, s1_zsign, s1_sub, s1_nan, s1_inf, s1_isign;
  logic [23:0] s1_mb, s1_ms;
  logic [7:0]  s1_exp;
  logic [4:0]  s1_d;

  logic [26:0] bx, bsh;
  logic        bstk;

  logic        s2_valid, s2_sign, s2_zsign, s2_nan, s2_inf, s2_isign;
  logic [27:0] s2_sum;
  logic [7:0]  s2_exp;

  logic [4:0]  lz;
  logic [7:0]  lim;

  logic        s3_valid, s3_sign, s3_zsign, s3_nan, s3_inf, s3_isign, s3_zero;
  logic [26:0] s3_s;
  logic [4:0]  s3_sh;
  logic [8:0]  s3_exp;

  logic [26:0] sn;
  logic [7:0]  exp_f;
  logic        inc, ovf;
  logic [30:0] rounded;
  logic [31:0] res;

  // Classify and order operands by magnitude.
  always_comb begin
    nan_a  = (a[30:23] == EXP_ALL) && (a[22:0] != '0);
    nan_b  = (b[30:23] == EXP_ALL) && (b[22:0] != '0);
    inf_a  = (a[30:23] == EXP_ALL) && (a[22:0] == '0);
    inf_b  = (b[30:23] == EXP_ALL) && (b[22:0] == '0);
    swap   = (b[30:0] > a[30:0]);
    big    = swap ? b : a;
    sml    = swap ? a : b;
    eb_eff = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    ediff  = eb_eff - es_eff;
  end

  // Stage 1: operand swap and exponent difference.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign  <= big[31];
      s1_zsign <= a[31] & b[31];
      s1_sub   <= a[31] ^ b[31];
      s1_nan   <= nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]));
      s1_inf   <= inf_a | inf_b;
      s1_isign <= inf_a ? a[31] : b[31];
      s1_mb    <= {big[30:23] != '0, big[22:0]};
      s1_ms    <= {sml[30:23] != '0, sml[22:0]};
      s1_exp   <= eb_eff;
      s1_d     <= (ediff > 8'd27) ? 5'd28 : ediff[4:0];
    end
  end

  // Stage 2: align the smaller operand with sticky, then add or subtract.
  always_comb begin
    bx   = {s1_ms, 3'b000};
    bsh  = bx >> s1_d;
    bstk = |(bx & ~({27{1'b1}} << s1_d));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign  <= s1_sign;
      s2_zsign <= s1_zsign;
      s2_nan   <= s1_nan;
      s2_inf   <= s1_inf;
      s2_isign <= s1_isign;
      s2_exp   <= s1_exp;
      if (s1_sub) begin
        s2_sum <= {1'b0, s1_mb, 3'b000} - {1'b0, bsh[26:1], bsh[0] | bstk};
      end else begin
        s2_sum <= {1'b0, s1_mb, 3'b000} + {1'b0, bsh[26:1], bsh[0] | bstk};
      end
    end
  end

  // Stage 3: leading-zero count, shift limited by the subnormal floor.
  always_comb begin
    lz  = lzc27(s2_sum[26:0]);
    lim = s2_exp - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign  <= s2_sign;
      s3_zsign <= s2_zsign;
      s3_nan   <= s2_nan;
      s3_inf   <= s2_inf;
      s3_isign <= s2_isign;
      s3_zero  <= (s2_sum == '0);
      if (s2_sum[27]) begin
        s3_s   <= {s2_sum[27:2], s2_sum[1] | s2_sum[0]};
        s3_sh  <= '0;
        s3_exp <= 9'(s2_exp) + 9'd1;
      end else if ({3'b000, lz} > lim) begin
        s3_s   <= s2_sum[26:0];
        s3_sh  <= lim[4:0];
        s3_exp <= 9'd1;
      end else begin
        s3_s   <= s2_sum[26:0];
        s3_sh  <= lz;
        s3_exp <= 9'(s2_exp) - 9'(lz);
      end
    end
  end

  // Stage 4: normalize, round to nearest even and pack.
  always_comb begin
    sn      = s3_s << s3_sh;
    exp_f   = sn[26] ? s3_exp[7:0] : 8'd0;
    ovf     = (s3_exp >= 9'd255);
    inc     = sn[2] & ((|sn[1:0]) | sn[3]);
    rounded = {exp_f, sn[25:3]} + 31'(inc);
    if (s3_nan) begin
      res = QNAN;
    end else if (s3_inf) begin
      res = {s3_isign, EXP_ALL, 23'd0};
    end else if (s3_zero) begin
      res = {s3_zsign, 31'd0};
    end else if (ovf) begin
      res = {s3_sign, EXP_ALL, 23'd0};
    end else begin
      res = {s3_sign, rounded};
    end
  end

  always_ff @(posedge clk) begin
    if (en) y <= res;
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      vout     <= 1'b0;
    end else if (en) begin
      s1_valid <= vin;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      vout     <= s3_valid;
    end
  end

endmodule

FILE: src/sgd_momentum_weight_update.sv
// Throughput: one item per cycle; the 20-stage pipeline (two multiplies and
// three adds of four stages each on the critical chain) advances as a whole
// whenever the output register is empty or being taken.
// Reset (synchronous, active high) clears all valid bits and sets the three
// configuration registers to zero.
module sgd_momentum_weight_update (
  input logic       clk,
  input logic       rst,
  sgdm_in_if.sink   in_ch,
  sgdm_out_if.source out_ch,
  sgdm_cfg_if.sink  cfg_ch
);
  import sgdm_pkg::*;

  logic [31:0] decay_factor, momentum_factor, learn_rate;
  logic        en;
  logic        v_p1, v_g2, v_m2, v_p3;
  logic [31:0] p1, p2, p2_d, g_d, g2, g2_d, m2, m2_d, p3, w_d;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor    <= '0;
      momentum_factor <= '0;
      learn_rate      <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DECAY:           decay_factor    <= cfg_ch.data;
        REG_MOMENTUM_FACTOR: momentum_factor <= cfg_ch.data;
        REG_LEARN_RATE:      learn_rate      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // The pipeline moves when the output register is free or being taken.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // w * decay_factor and m * momentum_factor in parallel.
  sgdm_fmul u_mul_wd (
    .clk(clk), .rst(rst), .en(en), .vin(in_ch.valid),
    .a(in_ch.weight_in), .b(decay_factor), .vout(v_p1), .y(p1)
  );

  sgdm_fmul u_mul_mf (
    .clk(clk), .rst(rst), .en(en), .vin(in_ch.valid),
    .a(in_ch.mbuf_in), .b(momentum_factor), .vout(), .y(p2)
  );

  sgdm_delay #(.W(32), .DEPTH(4)) u_dly_g (
    .clk(clk), .en(en), .d(in_ch.grad_in), .q(g_d)
  );

  // g' = g + w * decay_factor.
  sgdm_fadd u_add_g (
    .clk(clk), .rst(rst), .en(en), .vin(v_p1), .a(g_d), .b(p1), .vout(v_g2), .y(g2)
  );

  sgdm_delay #(.W(32), .DEPTH(4)) u_dly_p2 (
    .clk(clk), .en(en), .d(p2), .q(p2_d)
  );

  // m' = m * momentum_factor + g'.
  sgdm_fadd u_add_m (
    .clk(clk), .rst(rst), .en(en), .vin(v_g2), .a(p2_d), .b(g2), .vout(v_m2), .y(m2)
  );

  // m' * learn_rate.
  sgdm_fmul u_mul_lr (
    .clk(clk), .rst(rst), .en(en), .vin(v_m2), .a(m2), .b(learn_rate), .vout(v_p3), .y(p3)
  );

  sgdm_delay #(.W(32), .DEPTH(16)) u_dly_w (
    .clk(clk), .en(en), .d(in_ch.weight_in), .q(w_d)
  );

  // w' = w + m' * learn_rate; its stage 4 register is the output register.
  sgdm_fadd u_add_w (
    .clk(clk), .rst(rst), .en(en), .vin(v_p3), .a(w_d), .b(p3),
    .vout(out_ch.valid), .y(out_ch.weight_out)
  );

  // Side results delayed to line up with the final sum.
  sgdm_delay #(.W(32), .DEPTH(12)) u_dly_g2 (
    .clk(clk), .en(en), .d(g2), .q(g2_d)
  );

  sgdm_delay #(.W(32), .DEPTH(8)) u_dly_m2 (
    .clk(clk), .en(en), .d(m2), .q(m2_d)
  );

  sgdm_delay #(.W(1), .DEPTH(20)) u_dly_last (
    .clk(clk), .en(en), .d(in_ch.last_element), .q(out_ch.last_out)
  );

  assign out_ch.grad_out = g2_d;
  assign out_ch.mbuf_out = m2_d;

endmodule

FILE: verif/sgdm_tb_if_note.sv
`timescale 1ns / 1ps

// Shared settings of the momentum update testbench.
package sgdm_tb_pkg;

  // One parameter element offered to the block.
  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] grad;
    logic [31:0] mbuf;
    logic        last;
  } elem_t;

  // One update result expected from the block.
  typedef struct packed {
    logic [31:0] grad;
    logic [31:0] mbuf;
    logic [31:0] weight;
    logic        last;
  } upd_t;

  localparam logic [1:0] REG_UNUSED = 2'd3;

endpackage

FILE: verif/tb_sgd_momentum_weight_update.sv
`timescale 1ns / 1ps

module tb_sgd_momentum_weight_update;
  import sgdm_pkg::*;
  import sgdm_tb_pkg::*;

  localparam int LATENCY = 20;
  localparam int PHASE_ITEMS = 165;

  logic clk;
  logic rst;

  sgdm_in_if  in_ch();
  sgdm_out_if out_ch();
  sgdm_cfg_if cfg_ch();

  sgd_momentum_weight_update i_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Local copy of the three configuration registers.
  logic [31:0] decay_q, momentum_q, rate_q;

  elem_t pending_elems[$];
  upd_t  expected_updates[$];

  int unsigned cycle_cnt;
  int unsigned accepted_cnt;
  int unsigned result_cnt;
  int unsigned mismatch_cnt;
  int unsigned cfg_write_cnt;
  logic        hold_off;
  logic        in_taken;

  // Widen a binary32 pattern into a binary64 pattern (exact).
  function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
    logic        s;
    logic [7:0]  ef;
    logic [22:0] ff;
    int          p;
    int          e;
    logic [51:0] frac;
    s = f[31];
    ef = f[30:23];
    ff = f[22:0];
    if (ef == EXP_ALL) begin
      return {s, 11'h7FF, ff, 29'd0};
    end
    if (ef == 8'd0 && ff == 23'd0) begin
      return {s, 63'd0};
    end
    if (ef == 8'd0) begin
      // Subnormal: normalize around the leading one.
      p = 0;
      for (int i = 0; i < 23; i++) begin
        if (ff[i]) p = i;
      end
      e = p - 149;
      frac = 52'({29'd0, ff} << (52 - p));
    end else begin
      e = int'(ef) - 127;
      frac = {ff, 29'd0};
    end
    return {s, 11'(e + 1023), frac};
  endfunction

  // Round a binary64 pattern to binary32, nearest-even, with gradual underflow.
  function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
    logic        s;
    logic [10:0] ed;
    logic [63:0] mant;
    logic [63:0] q;
    logic        rbit;
    logic        sticky;
    int          e;
    int          sh;
    s = d[63];
    ed = d[62:52];
    if (ed == 11'h7FF) begin
      if (d[51:0] != 52'd0) return QNAN;
      return {s, EXP_ALL, 23'd0};
    end
    if (ed == 11'd0) return {s, 31'd0};
    e = int'(ed) - 1023;
    if (e > 127) return {s, EXP_ALL, 23'd0};
    mant = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    q = mant >> sh;
    rbit = mant[sh-1];
    sticky = |(mant & ((64'd1 << (sh - 1)) - 64'd1));
    if (rbit && (sticky || q[0])) q = q + 64'd1;
    if (e >= -126) begin
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        e = e + 1;
      end
      if (e > 127) return {s, EXP_ALL, 23'd0};
      return {s, 8'(e + 127), q[22:0]};
    end
    // A carry into bit 23 lands on the smallest normal exponent by itself.
    return {s, q[30:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    return f64_to_f32($realtobits($bitstoreal(f32_to_f64(a)) * $bitstoreal(f32_to_f64(b))));
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    return f64_to_f32($realtobits($bitstoreal(f32_to_f64(a)) + $bitstoreal(f32_to_f64(b))));
  endfunction

  // Expected update for one element under the current registers.
  function automatic upd_t sgd_update(input elem_t x);
    upd_t r;
    r.grad = fadd(x.grad, fmul(x.weight, decay_q));
    r.mbuf = fadd(fmul(x.mbuf, momentum_q), r.grad);
    r.weight = fadd(x.weight, fmul(r.mbuf, rate_q));
    r.last = x.last;
    return r;
  endfunction

  function automatic logic [31:0] special_f32();
    logic [31:0] vals[12];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
             32'h0080_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000};
    return vals[$urandom_range(11)];
  endfunction

  // Mostly ordinary magnitudes so that the sums interact, plus edge patterns.
  function automatic logic [31:0] rand_f32();
    case ($urandom_range(9))
      0: return special_f32();
      1: return {1'($urandom), 8'd0, 23'($urandom)};
      2: return $urandom;
      3: return {1'($urandom), 8'($urandom_range(200, 254)), 23'($urandom)};
      4: return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(115, 135)), 23'($urandom)};
    endcase
  endfunction

  function automatic elem_t rand_elem();
    elem_t x;
    x.weight = rand_f32();
    x.grad = rand_f32();
    x.mbuf = rand_f32();
    x.last = 1'($urandom);
    return x;
  endfunction

  // Clock and reset.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Remember whether the offered item was taken at the last rising edge.
  always @(posedge clk) in_taken <= in_ch.valid && in_ch.ready;

  // No idling on either side in this window.
  function automatic logic calm_window();
    return cycle_cnt >= 1200 && cycle_cnt < 1900;
  endfunction

  // Input driver: holds an item until it is taken, idles at random between items.
  always @(negedge clk) begin
    if (!rst && (!in_ch.valid || in_taken)) begin
      if (pending_elems.size() > 0 && (calm_window() || $urandom_range(99) >= 11)) begin
        elem_t x;
        x = pending_elems.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.weight_in    <= x.weight;
        in_ch.grad_in      <= x.grad;
        in_ch.mbuf_in      <= x.mbuf;
        in_ch.last_element <= x.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off.
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm_window() || ($urandom_range(99) >= 11);
  end

  initial begin
    hold_off = 1'b0;
    wait (accepted_cnt >= 420);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
  end

  // Accepted items are predicted; results are checked against the oldest one.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      expected_updates.insert(expected_updates.size(),
                              sgd_update({in_ch.weight_in, in_ch.grad_in,
                                          in_ch.mbuf_in, in_ch.last_element}));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      upd_t got;
      upd_t want;
      got = {out_ch.grad_out, out_ch.mbuf_out, out_ch.weight_out, out_ch.last_out};
      result_cnt <= result_cnt + 1;
      if (expected_updates.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_updates.pop_front();
        if (got != want) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("mismatch g %h/%h m %h/%h w %h/%h last %b/%b (exp/act)",
                     want.grad, got.grad, want.mbuf, got.mbuf,
                     want.weight, got.weight, want.last, got.last);
        end
      end
    end
  end

  // Configuration write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_DECAY:           decay_q = val;
      REG_MOMENTUM_FACTOR: momentum_q = val;
      REG_LEARN_RATE:      rate_q = val;
      default: ;
    endcase
    cfg_write_cnt++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] wd, input logic [31:0] mf, input logic [31:0] lr);
    write_reg(REG_DECAY, wd);
    write_reg(REG_MOMENTUM_FACTOR, mf);
    write_reg(REG_LEARN_RATE, lr);
  endtask

  // Queue one element for the driver.
  task automatic add_elem(input elem_t x);
    pending_elems.insert(pending_elems.size(), x);
  endtask

  // Wait until every offered item has produced its result, then let the pipe settle.
  task automatic wait_drained();
    while (pending_elems.size() > 0 || in_ch.valid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_phase(input int n);
    repeat (n) add_elem(rand_elem());
    wait_drained();
  endtask

  initial begin
    decay_q = '0;
    momentum_q = '0;
    rate_q = '0;
    cycle_cnt = 0;
    accepted_cnt = 0;
    result_cnt = 0;
    mismatch_cnt = 0;
    cfg_write_cnt = 0;
    in_ch.valid = 1'b0;
    in_ch.weight_in = '0;
    in_ch.grad_in = '0;
    in_ch.mbuf_in = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_DECAY;
    cfg_ch.data = '0;
    wait (!rst);

    // Registers at their reset value; a write to the unused index changes nothing.
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    random_phase(30);

    // Directed: signed zeros, infinities, NaNs, subnormals, overflow, inf*0, inf-inf.
    set_regs(32'h3A83_126F, 32'h3F66_6666, 32'hBC23_D70A);
    add_elem({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0});
    add_elem({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1});
    add_elem({32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 1'b0});
    add_elem({32'hFF80_0000, 32'h3F80_0000, 32'h7F80_0000, 1'b0});
    add_elem({32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1});
    add_elem({32'h3F80_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 1'b0});
    add_elem({32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0001, 1'b0});
    add_elem({32'h0000_0001, 32'h0000_0001, 32'h8000_0001, 1'b1});
    add_elem({32'h007F_FFFF, 32'h0000_0001, 32'h0080_0000, 1'b0});
    add_elem({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0});
    add_elem({32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF, 1'b1});
    add_elem({32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 1'b0});
    add_elem({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    add_elem({32'h4B80_0000, 32'h3F80_0001, 32'h3380_0000, 1'b0});
    random_phase(0);

    set_regs(32'h7F80_0000, 32'h0000_0001, 32'h7F7F_FFFF);
    add_elem({32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0});
    add_elem({32'h3F80_0000, 32'hFF80_0000, 32'h0000_0000, 1'b1});
    add_elem({32'h8000_0001, 32'h0000_0000, 32'h7F80_0000, 1'b0});
    random_phase(PHASE_ITEMS);

    // Typical training settings with random content.
    for (int ph = 0; ph < 5; ph++) begin
      set_regs({1'b0, 8'($urandom_range(105, 125)), 23'($urandom)},
               {1'b0, 8'($urandom_range(118, 126)), 23'($urandom)},
               {1'($urandom), 8'($urandom_range(100, 125)), 23'($urandom)});
      random_phase(PHASE_ITEMS);
    end

    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(40);
    set_regs($urandom, $urandom, $urandom);
    random_phase(PHASE_ITEMS);
    set_regs(32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001);
    random_phase(PHASE_ITEMS);

    $display("Covered %0d elements and %0d results over %0d register writes,",
             accepted_cnt, result_cnt, cfg_write_cnt);
    $display("including IEEE special values, subnormals and a long output stall.");
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #800000;
    $display("timeout");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
